FILE: src/ptss_pkg.sv
// Shared types and constants of the pan/tilt command slew servo.
`default_nettype none

package ptss_pkg;

  // Input word: request kind and received character
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_word_t;

  // Result word: servo pulses and current angles
  typedef struct packed {
    logic [11:0] pan_pulse_us;
    logic [11:0] tilt_pulse_us;
    logic [7:0]  pan_angle;
    logic [7:0]  tilt_angle;
  } out_word_t;

  // Configuration register file
  typedef struct packed {
    logic [3:0] ramp_step_deg;
    logic [8:0] idle_timeout_ticks;
    logic [6:0] home_pan_deg;
    logic [7:0] home_tilt_deg;
    logic [6:0] step_level_one;
    logic [6:0] step_level_two;
    logic [6:0] step_level_three;
    logic [7:0] pan_limit_deg;
  } cfg_t;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    LVL_ONE   = 2'd0,
    LVL_TWO   = 2'd1,
    LVL_THREE = 2'd2
  } level_t;

  // Decoded command of a finished line
  typedef struct packed {
    logic   home;
    logic   move;
    level_t level;
    dir_t   pan_dir;
    dir_t   tilt_dir;
  } cmd_t;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_IDLE = 2'd1;
  localparam logic [1:0] REQ_RAMP = 2'd2;

  localparam logic [2:0] CFG_RAMP_STEP    = 3'd0;
  localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_HOME_PAN     = 3'd2;
  localparam logic [2:0] CFG_HOME_TILT    = 3'd3;
  localparam logic [2:0] CFG_STEP_ONE     = 3'd4;
  localparam logic [2:0] CFG_STEP_TWO     = 3'd5;
  localparam logic [2:0] CFG_STEP_THREE   = 3'd6;
  localparam logic [2:0] CFG_PAN_LIMIT    = 3'd7;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_AT  = 8'h40;
  localparam logic [7:0] CH_R   = 8'h52;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_TWO = 8'h32;
  localparam logic [7:0] CH_THR = 8'h33;
  localparam logic [7:0] CH_Q   = 8'h51;
  localparam logic [7:0] CH_W   = 8'h57;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_Z   = 8'h5A;
  localparam logic [7:0] CH_X   = 8'h58;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [7:0]  FULL_DEG   = 8'd180;
  localparam logic [11:0] PULSE_BASE = 12'd500;
  localparam logic [11:0] PULSE_TOP  = 12'd2500;
  // 2000/180 = 100/9; 100 * ceil(2^18 / 9), exact for angles up to 255
  localparam logic [21:0] PULSE_RECIP = 22'd2912800;
  localparam int          PULSE_SHIFT = 18;

  localparam cfg_t CFG_RESET = '{
    ramp_step_deg:      4'd2,
    idle_timeout_ticks: 9'd300,
    home_pan_deg:       7'd0,
    home_tilt_deg:      8'd90,
    step_level_one:     7'd30,
    step_level_two:     7'd20,
    step_level_three:   7'd10,
    pan_limit_deg:      8'd90
  };

endpackage

`default_nettype wire

FILE: src/ptss_line_asm.sv
// Line assembler: gathers received characters and decodes a finished line.
`default_nettype none

module ptss_line_asm #(
  parameter int LINE_CAPACITY = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_fire,
  input  wire logic [7:0]    rx_byte,
  output ptss_pkg::cmd_t     cmd
);

  localparam int LenW = $clog2(LINE_CAPACITY);

  logic [LenW-1:0] len_r, len_nxt;
  logic [7:0]      head_r [3];
  logic            is_lf, is_cr, has_room, lvl_ok, grid_ok;

  assign is_lf    = (rx_byte == ptss_pkg::CH_LF);
  assign is_cr    = (rx_byte == ptss_pkg::CH_CR);
  assign has_room = (len_r < LenW'(LINE_CAPACITY - 1));

  always_comb begin
    len_nxt = len_r;
    if (byte_fire && !is_cr) begin
      if (is_lf) begin
        len_nxt = '0;
      end else if (has_room) begin
        len_nxt = len_r + LenW'(1);
      end else begin
        // overlong line: drop it with this character
        len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // keep only the first three characters
  always_ff @(posedge clk) begin
    if (byte_fire && !is_cr && !is_lf && has_room && (len_r < LenW'(3))) begin
      head_r[len_r[1:0]] <= rx_byte;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.level    = ptss_pkg::LVL_ONE;
    cmd.pan_dir  = ptss_pkg::DIR_HOLD;
    cmd.tilt_dir = ptss_pkg::DIR_HOLD;
    lvl_ok       = 1'b1;
    grid_ok      = 1'b1;
    case (head_r[2])
      ptss_pkg::CH_ONE: cmd.level = ptss_pkg::LVL_ONE;
      ptss_pkg::CH_TWO: cmd.level = ptss_pkg::LVL_TWO;
      ptss_pkg::CH_THR: cmd.level = ptss_pkg::LVL_THREE;
      default:          lvl_ok    = 1'b0;
    endcase
    case (head_r[0])
      ptss_pkg::CH_Q: begin
        cmd.pan_dir  = ptss_pkg::DIR_INC;
        cmd.tilt_dir = ptss_pkg::DIR_INC;
      end
      ptss_pkg::CH_W: cmd.pan_dir = ptss_pkg::DIR_INC;
      ptss_pkg::CH_E: begin
        cmd.pan_dir  = ptss_pkg::DIR_INC;
        cmd.tilt_dir = ptss_pkg::DIR_DEC;
      end
      ptss_pkg::CH_A: cmd.tilt_dir = ptss_pkg::DIR_INC;
      ptss_pkg::CH_D: cmd.tilt_dir = ptss_pkg::DIR_DEC;
      ptss_pkg::CH_Z: begin
        cmd.pan_dir  = ptss_pkg::DIR_DEC;
        cmd.tilt_dir = ptss_pkg::DIR_INC;
      end
      ptss_pkg::CH_X: cmd.pan_dir = ptss_pkg::DIR_DEC;
      ptss_pkg::CH_C: begin
        cmd.pan_dir  = ptss_pkg::DIR_DEC;
        cmd.tilt_dir = ptss_pkg::DIR_DEC;
      end
      default: grid_ok = 1'b0;
    endcase
    cmd.home = is_lf && (len_r == LenW'(1)) && (head_r[0] == ptss_pkg::CH_R);
    cmd.move = is_lf && (len_r >= LenW'(3)) && (head_r[1] == ptss_pkg::CH_AT)
               && lvl_ok && grid_ok;
  end

endmodule

`default_nettype wire

FILE: src/ptss_servo.sv
// Target, current angle and idle timer state with homing and slewing.
`default_nettype none

module ptss_servo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic [1:0]     req_type,
  input  wire ptss_pkg::cmd_t cmd,
  input  wire ptss_pkg::cfg_t cfg,
  output logic [7:0]          pan_nxt,
  output logic [7:0]          tilt_nxt
);

  logic [7:0] tgt_pan_r, tgt_pan_nxt, tgt_tilt_r, tgt_tilt_nxt;
  logic [7:0] cur_pan_r, cur_tilt_r;
  logic [8:0] idle_r, idle_nxt;
  logic       home_sent_r, home_sent_nxt;
  logic [7:0] pan_max, home_pan_c, home_tilt_c;
  logic [6:0] step;
  logic [9:0] idle_inc;
  logic signed [10:0] pan_mv, tilt_mv;

  function automatic logic [7:0] clamp_deg(input logic signed [10:0] v,
                                           input logic [7:0] hi);
    if (v < 11'sd0) begin
      return 8'd0;
    end else if (v > $signed({3'b000, hi})) begin
      return hi;
    end
    return v[7:0];
  endfunction

  function automatic logic signed [10:0] apply_dir(input logic [7:0] cur,
                                                   input logic [6:0] stp,
                                                   input ptss_pkg::dir_t dir);
    case (dir)
      ptss_pkg::DIR_INC: return $signed({3'b000, cur}) + $signed({4'b0000, stp});
      ptss_pkg::DIR_DEC: return $signed({3'b000, cur}) - $signed({4'b0000, stp});
      default:           return $signed({3'b000, cur});
    endcase
  endfunction

  function automatic logic [7:0] slew_deg(input logic [7:0] cur, input logic [7:0] tgt,
                                          input logic [3:0] r, input logic [7:0] hi);
    logic signed [10:0] d, rs;
    d  = $signed({3'b000, tgt}) - $signed({3'b000, cur});
    rs = $signed({7'd0, r});
    if (d > rs) d = rs;
    if (d < -rs) d = -rs;
    if (d == 11'sd0) return cur;
    return clamp_deg($signed({3'b000, cur}) + d, hi);
  endfunction

  assign pan_max = (cfg.pan_limit_deg > ptss_pkg::FULL_DEG) ? ptss_pkg::FULL_DEG
                                                            : cfg.pan_limit_deg;
  assign home_pan_c  = clamp_deg($signed({4'b0000, cfg.home_pan_deg}), pan_max);
  assign home_tilt_c = clamp_deg($signed({3'b000, cfg.home_tilt_deg}),
                                 ptss_pkg::FULL_DEG);
  assign idle_inc    = {1'b0, idle_r} + 10'd1;

  always_comb begin
    case (cmd.level)
      ptss_pkg::LVL_TWO:   step = cfg.step_level_two;
      ptss_pkg::LVL_THREE: step = cfg.step_level_three;
      default:             step = cfg.step_level_one;
    endcase
  end

  assign pan_mv  = apply_dir(cur_pan_r, step, cmd.pan_dir);
  assign tilt_mv = apply_dir(cur_tilt_r, step, cmd.tilt_dir);

  always_comb begin
    tgt_pan_nxt   = tgt_pan_r;
    tgt_tilt_nxt  = tgt_tilt_r;
    pan_nxt       = cur_pan_r;
    tilt_nxt      = cur_tilt_r;
    idle_nxt      = idle_r;
    home_sent_nxt = home_sent_r;
    if (fire) begin
      case (req_type)
        ptss_pkg::REQ_BYTE: begin
          idle_nxt      = '0;
          home_sent_nxt = 1'b0;
          if (cmd.home) begin
            tgt_pan_nxt  = home_pan_c;
            tgt_tilt_nxt = home_tilt_c;
          end else if (cmd.move) begin
            tgt_pan_nxt  = clamp_deg(pan_mv, pan_max);
            tgt_tilt_nxt = clamp_deg(tilt_mv, ptss_pkg::FULL_DEG);
          end
        end
        ptss_pkg::REQ_IDLE: begin
          if (idle_inc >= {1'b0, cfg.idle_timeout_ticks}) begin
            // saturate at the timeout and home only once
            idle_nxt = cfg.idle_timeout_ticks;
            if (!home_sent_r) begin
              tgt_pan_nxt   = home_pan_c;
              tgt_tilt_nxt  = home_tilt_c;
              home_sent_nxt = 1'b1;
            end
          end else begin
            idle_nxt = idle_inc[8:0];
          end
        end
        ptss_pkg::REQ_RAMP: begin
          pan_nxt  = slew_deg(cur_pan_r, tgt_pan_r, cfg.ramp_step_deg, pan_max);
          tilt_nxt = slew_deg(cur_tilt_r, tgt_tilt_r, cfg.ramp_step_deg,
                              ptss_pkg::FULL_DEG);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_pan_r   <= 8'd0;
      tgt_tilt_r  <= 8'd90;
      cur_pan_r   <= 8'd0;
      cur_tilt_r  <= 8'd90;
      idle_r      <= '0;
      home_sent_r <= 1'b0;
    end else begin
      tgt_pan_r   <= tgt_pan_nxt;
      tgt_tilt_r  <= tgt_tilt_nxt;
      cur_pan_r   <= pan_nxt;
      cur_tilt_r  <= tilt_nxt;
      idle_r      <= idle_nxt;
      home_sent_r <= home_sent_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/ptss_result.sv
// Result register: converts angles to servo pulse widths and holds the word.
`default_nettype none

module ptss_result (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire logic [7:0]     pan_in,
  input  wire logic [7:0]     tilt_in,
  output logic                free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ptss_pkg::out_word_t out_data
);

  logic                valid_r, valid_nxt;
  ptss_pkg::out_word_t data_r;

  // 500 + floor(100*deg/9) by reciprocal multiply
  function automatic logic [11:0] pulse_of(input logic [7:0] deg);
    logic [29:0] prod;
    prod = {22'd0, deg} * {8'd0, ptss_pkg::PULSE_RECIP};
    return ptss_pkg::PULSE_BASE + prod[ptss_pkg::PULSE_SHIFT +: 12];
  endfunction

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r.pan_pulse_us  <= pulse_of(pan_in);
      data_r.tilt_pulse_us <= pulse_of(tilt_in);
      data_r.pan_angle     <= pan_in;
      data_r.tilt_angle    <= tilt_in;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: src/pan_tilt_command_slew_servo_core.sv
// Top level of the pan/tilt command slew servo.
//
// Input channel (in_valid/in_ready/in_data) carries one word per event:
// a received character, an idle tick or a ramp tick. Every accepted word
// yields exactly one result word on the output channel (out_valid/out_ready/
// out_data) with both pulse widths and both current angles after the event.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high and a write takes effect next cycle.
// An accepted word sits in the input register and leaves it when the result
// register is free; its result is loaded into the result register as it
// leaves. Throughput: one word per cycle while the receiver takes results,
// since the state update between the two registers is combinational.
// When the receiver stalls, the result register holds its word, the input
// register holds one more, and in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, clears the line
// buffer and idle timer, sets pan 0 / tilt 90 for target and current, and
// restores the configuration defaults.
`default_nettype none

module pan_tilt_command_slew_servo_core #(
  parameter int LINE_CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ptss_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptss_pkg::out_word_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);

  logic               s1_valid_r, s1_valid_nxt;
  ptss_pkg::in_word_t s1_data_r;
  ptss_pkg::cfg_t     cfg_r, cfg_nxt;
  ptss_pkg::cmd_t     cmd;
  logic               res_free, fire, byte_fire;
  logic [7:0]         pan_nxt, tilt_nxt;

  assign cfg_ready    = 1'b1;
  assign fire         = s1_valid_r && res_free;
  assign byte_fire    = fire && (s1_data_r.req_type == ptss_pkg::REQ_BYTE);
  assign in_ready     = !s1_valid_r || fire;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ptss_pkg::CFG_RAMP_STEP:    cfg_nxt.ramp_step_deg      = cfg_data[3:0];
        ptss_pkg::CFG_IDLE_TIMEOUT: cfg_nxt.idle_timeout_ticks = cfg_data;
        ptss_pkg::CFG_HOME_PAN:     cfg_nxt.home_pan_deg       = cfg_data[6:0];
        ptss_pkg::CFG_HOME_TILT:    cfg_nxt.home_tilt_deg      = cfg_data[7:0];
        ptss_pkg::CFG_STEP_ONE:     cfg_nxt.step_level_one     = cfg_data[6:0];
        ptss_pkg::CFG_STEP_TWO:     cfg_nxt.step_level_two     = cfg_data[6:0];
        ptss_pkg::CFG_STEP_THREE:   cfg_nxt.step_level_three   = cfg_data[6:0];
        ptss_pkg::CFG_PAN_LIMIT:    cfg_nxt.pan_limit_deg      = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ptss_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ptss_line_asm #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_line_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (s1_data_r.rx_byte),
    .cmd       (cmd)
  );

  ptss_servo u_servo (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req_type (s1_data_r.req_type),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .pan_nxt  (pan_nxt),
    .tilt_nxt (tilt_nxt)
  );

  ptss_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .pan_in    (pan_nxt),
    .tilt_in   (tilt_nxt),
    .free      (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a word leaving the input register always lands in the result register
  a_fire_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("result not loaded after input register advanced");

  a_angles_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pan_angle <= ptss_pkg::FULL_DEG)
                  && (out_data.tilt_angle <= ptss_pkg::FULL_DEG))
    else $error("angle out of range");

  a_pulse_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pan_pulse_us >= ptss_pkg::PULSE_BASE)
                  && (out_data.pan_pulse_us <= ptss_pkg::PULSE_TOP)
                  && (out_data.tilt_pulse_us >= ptss_pkg::PULSE_BASE)
                  && (out_data.tilt_pulse_us <= ptss_pkg::PULSE_TOP))
    else $error("pulse width out of range");

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the pan/tilt command slew servo core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CAPACITY = 16;
  localparam int PULSE_SPAN    = 2000;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [1:0] REQ_NONE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ptss_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ptss_pkg::out_word_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [8:0]          cfg_data = '0;

  pan_tilt_command_slew_servo_core #(.LINE_CAPACITY(LINE_CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Servo state as the block should hold it
  ptss_pkg::cfg_t servo_cfg = ptss_pkg::CFG_RESET;
  logic [3:0] line_len = '0;
  logic [7:0] line_head [3] = '{8'd0, 8'd0, 8'd0};
  logic [7:0] tgt_pan = 8'd0;
  logic [7:0] tgt_tilt = 8'd90;
  logic [7:0] cur_pan = 8'd0;
  logic [7:0] cur_tilt = 8'd90;
  logic [8:0] idle_count = '0;
  logic       home_sent = 1'b0;

  ptss_pkg::in_word_t  servo_req_q [$];
  ptss_pkg::out_word_t pose_expect_q [$];

  int   fail_count = 0;
  int   words_in = 0;
  int   words_out = 0;
  int   reg_writes = 0;
  int   settings_used = 0;
  int   cycle_count = 0;
  int   tx_gap = 0;
  int   rx_hold = 0;
  int   squeeze_left = 0;
  logic calm = 1'b0;
  logic squeeze_req = 1'b0;
  logic squeeze_done = 1'b0;

  function automatic int fit(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void aim(int p, int t, int pan_hi);
    tgt_pan  = 8'(fit(p, pan_hi));
    tgt_tilt = 8'(fit(t, ptss_pkg::FULL_DEG));
  endfunction

  function automatic void finish_line(int pan_hi);
    int amount, dp, dt, cp, ct;
    dp = 0;
    dt = 0;
    cp = cur_pan;
    ct = cur_tilt;
    if (line_len == 1 && line_head[0] == ptss_pkg::CH_R) begin
      aim(servo_cfg.home_pan_deg, servo_cfg.home_tilt_deg, pan_hi);
      return;
    end
    if (line_len < 3 || line_head[1] != ptss_pkg::CH_AT) return;
    case (line_head[2])
      ptss_pkg::CH_ONE: amount = servo_cfg.step_level_one;
      ptss_pkg::CH_TWO: amount = servo_cfg.step_level_two;
      ptss_pkg::CH_THR: amount = servo_cfg.step_level_three;
      default: return;
    endcase
    // row picks the pan direction, column the tilt direction
    case (line_head[0])
      ptss_pkg::CH_Q: begin dp = 1;  dt = 1;  end
      ptss_pkg::CH_W: begin dp = 1;  dt = 0;  end
      ptss_pkg::CH_E: begin dp = 1;  dt = -1; end
      ptss_pkg::CH_A: begin dp = 0;  dt = 1;  end
      ptss_pkg::CH_D: begin dp = 0;  dt = -1; end
      ptss_pkg::CH_Z: begin dp = -1; dt = 1;  end
      ptss_pkg::CH_X: begin dp = -1; dt = 0;  end
      ptss_pkg::CH_C: begin dp = -1; dt = -1; end
      default: return;
    endcase
    aim(cp + dp * amount, ct + dt * amount, pan_hi);
  endfunction

  function automatic void take_char(logic [7:0] ch, int pan_hi);
    idle_count = '0;
    home_sent  = 1'b0;
    if (ch == ptss_pkg::CH_CR) return;
    if (ch == ptss_pkg::CH_LF) begin
      if (line_len != 0) begin
        finish_line(pan_hi);
        line_len = '0;
      end
      return;
    end
    if (line_len < LINE_CAPACITY - 1) begin
      if (line_len < 3) line_head[line_len[1:0]] = ch;
      line_len++;
    end else begin
      // overrun: drop the line and this char
      line_len = '0;
    end
  endfunction

  function automatic logic [7:0] slew(logic [7:0] now, logic [7:0] goal, int hi);
    int d, r, n, g;
    r = servo_cfg.ramp_step_deg;
    n = now;
    g = goal;
    d = g - n;
    if (d > r) d = r;
    if (d < -r) d = -r;
    if (d == 0) return now;
    return 8'(fit(n + d, hi));
  endfunction

  function automatic ptss_pkg::out_word_t servo_step(ptss_pkg::in_word_t w);
    ptss_pkg::out_word_t r;
    int pan_hi, bump, cp, ct;
    pan_hi = (servo_cfg.pan_limit_deg > ptss_pkg::FULL_DEG) ? ptss_pkg::FULL_DEG
                                                            : servo_cfg.pan_limit_deg;
    case (w.req_type)
      ptss_pkg::REQ_BYTE: take_char(w.rx_byte, pan_hi);
      ptss_pkg::REQ_IDLE: begin
        bump = idle_count + 1;
        if (bump >= servo_cfg.idle_timeout_ticks) begin
          idle_count = servo_cfg.idle_timeout_ticks;
          if (!home_sent) begin
            aim(servo_cfg.home_pan_deg, servo_cfg.home_tilt_deg, pan_hi);
            home_sent = 1'b1;
          end
        end else begin
          idle_count = 9'(bump);
        end
      end
      ptss_pkg::REQ_RAMP: begin
        cur_pan  = slew(cur_pan, tgt_pan, pan_hi);
        cur_tilt = slew(cur_tilt, tgt_tilt, ptss_pkg::FULL_DEG);
      end
      default: ;
    endcase
    cp = cur_pan;
    ct = cur_tilt;
    r.pan_pulse_us  = 12'(ptss_pkg::PULSE_BASE + (PULSE_SPAN * cp) / ptss_pkg::FULL_DEG);
    r.tilt_pulse_us = 12'(ptss_pkg::PULSE_BASE + (PULSE_SPAN * ct) / ptss_pkg::FULL_DEG);
    r.pan_angle     = cur_pan;
    r.tilt_angle    = cur_tilt;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Driver: offer queued words, with random gaps between them
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pose_expect_q.push_back(servo_step(in_data));
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (servo_req_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= servo_req_q.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall: hold off long enough for the block to back up
  always @(posedge clk) begin
    if (squeeze_req && !squeeze_done) begin
      squeeze_done <= 1'b1;
      squeeze_left <= 60;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
    end
  end

  // Monitor: check each result word, stall the output now and then
  always @(posedge clk) begin : watch_results
    ptss_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_expect_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        want = pose_expect_q.pop_front();
        check_field("pan_pulse_us", want.pan_pulse_us, out_data.pan_pulse_us);
        check_field("tilt_pulse_us", want.tilt_pulse_us, out_data.tilt_pulse_us);
        check_field("pan_angle", want.pan_angle, out_data.pan_angle);
        check_field("tilt_angle", want.tilt_angle, out_data.tilt_angle);
        words_out++;
      end
    end
    if (squeeze_left > 0) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      rx_hold = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pan_tilt_command_slew_servo_core verification failed");
      $finish;
    end
  end

  function automatic void put(logic [1:0] kind, logic [7:0] ch);
    ptss_pkg::in_word_t w;
    w.req_type = kind;
    w.rx_byte  = ch;
    servo_req_q.push_back(w);
  endfunction

  function automatic void put_char(logic [7:0] ch);
    put(ptss_pkg::REQ_BYTE, ch);
  endfunction

  function automatic void put_line(string s, bit with_cr);
    foreach (s[i]) put_char(s[i]);
    if (with_cr) put_char(ptss_pkg::CH_CR);
    put_char(ptss_pkg::CH_LF);
  endfunction

  function automatic void queue_traffic(int count);
    int goal, pick, n;
    string grid;
    grid = "QWEASDZXC";
    goal = servo_req_q.size() + count;
    while (servo_req_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // move command, mostly well formed, then let the servos slew
        if ($urandom_range(0, 9) != 0) put_char(grid[$urandom_range(0, 8)]);
        else put_char(8'($urandom_range(8'h20, 8'h7E)));
        put_char(($urandom_range(0, 19) != 0) ? ptss_pkg::CH_AT : 8'($urandom));
        put_char(($urandom_range(0, 9) != 0)
                 ? 8'(ptss_pkg::CH_ONE + $urandom_range(0, 2)) : 8'($urandom));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) put_char(8'($urandom_range(8'h21, 8'h7E)));
        if ($urandom_range(0, 3) == 0) put_char(ptss_pkg::CH_CR);
        put_char(ptss_pkg::CH_LF);
        repeat ($urandom_range(1, 5)) put(ptss_pkg::REQ_RAMP, 8'($urandom));
      end else if (pick < 48) begin
        put_char(ptss_pkg::CH_R);
        if ($urandom_range(0, 3) == 0) put_char(8'($urandom_range(8'h21, 8'h7E)));
        put_char(ptss_pkg::CH_LF);
        repeat ($urandom_range(1, 4)) put(ptss_pkg::REQ_RAMP, 8'($urandom));
      end else if (pick < 66) begin
        repeat ($urandom_range(1, 8)) put(ptss_pkg::REQ_RAMP, 8'($urandom));
      end else if (pick < 76) begin
        repeat ($urandom_range(1, 24)) put(ptss_pkg::REQ_IDLE, 8'($urandom));
      end else if (pick < 86) begin
        put(2'($urandom_range(0, 3)), 8'($urandom));
      end else if (pick < 92) begin
        // push the line near or past its capacity, then maybe append a command
        repeat ($urandom_range(14, 16)) put_char(8'($urandom_range(8'h21, 8'h7E)));
        if ($urandom_range(0, 1) == 0) begin
          put_char(grid[$urandom_range(0, 8)]);
          put_char(ptss_pkg::CH_AT);
          put_char(8'(ptss_pkg::CH_ONE + $urandom_range(0, 2)));
        end
        put_char(ptss_pkg::CH_LF);
      end else if (pick < 96) begin
        if ($urandom_range(0, 1) == 0) put_char(ptss_pkg::CH_CR);
        put_char(ptss_pkg::CH_LF);
      end else begin
        put(REQ_NONE, 8'($urandom));
      end
    end
  endfunction

  task automatic cfg_write(logic [2:0] idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[8:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ptss_pkg::CFG_RAMP_STEP:    servo_cfg.ramp_step_deg      = value[3:0];
      ptss_pkg::CFG_IDLE_TIMEOUT: servo_cfg.idle_timeout_ticks = value[8:0];
      ptss_pkg::CFG_HOME_PAN:     servo_cfg.home_pan_deg       = value[6:0];
      ptss_pkg::CFG_HOME_TILT:    servo_cfg.home_tilt_deg      = value[7:0];
      ptss_pkg::CFG_STEP_ONE:     servo_cfg.step_level_one     = value[6:0];
      ptss_pkg::CFG_STEP_TWO:     servo_cfg.step_level_two     = value[6:0];
      ptss_pkg::CFG_STEP_THREE:   servo_cfg.step_level_three   = value[6:0];
      ptss_pkg::CFG_PAN_LIMIT:    servo_cfg.pan_limit_deg      = value[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic load_settings(int ramp, int timeout, int hpan, int htilt,
                               int s1, int s2, int s3, int plim);
    cfg_write(ptss_pkg::CFG_RAMP_STEP, ramp);
    cfg_write(ptss_pkg::CFG_IDLE_TIMEOUT, timeout);
    cfg_write(ptss_pkg::CFG_HOME_PAN, hpan);
    cfg_write(ptss_pkg::CFG_HOME_TILT, htilt);
    cfg_write(ptss_pkg::CFG_STEP_ONE, s1);
    cfg_write(ptss_pkg::CFG_STEP_TWO, s2);
    cfg_write(ptss_pkg::CFG_STEP_THREE, s3);
    cfg_write(ptss_pkg::CFG_PAN_LIMIT, plim);
    settings_used++;
  endtask

  task automatic load_random_settings();
    load_settings($urandom_range(1, 15), $urandom_range(1, 40), $urandom_range(0, 90),
                  $urandom_range(0, 180), $urandom_range(0, 90), $urandom_range(0, 90),
                  $urandom_range(0, 90), $urandom_range(0, 180));
  endtask

  // Wait until every queued word went in and every result came back
  task automatic drain();
    do @(negedge clk);
    while (servo_req_q.size() != 0 || in_valid || pose_expect_q.size() != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    put(ptss_pkg::REQ_RAMP, 8'hFF);
    put_line("R", 1'b0);
    put_line("Q@1", 1'b0);
    put(ptss_pkg::REQ_RAMP, 8'h00);
    put_line("C@3", 1'b1);
    put_char(ptss_pkg::CH_LF);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(ptss_pkg::CH_LF);
    put(REQ_NONE, 8'hA5);
    put(ptss_pkg::REQ_IDLE, 8'h5A);
    put(ptss_pkg::REQ_RAMP, 8'h00);
    put_line("S@2", 1'b0);
    put(ptss_pkg::REQ_RAMP, 8'hFF);
    drain();

    load_settings(15, 1, 90, 180, 90, 90, 90, 180);
    queue_traffic(90);
    drain();

    load_settings(1, 511, 0, 0, 0, 1, 2, 0);
    queue_traffic(80);
    drain();

    // values past the documented ranges: zero step, zero timeout, wide limits
    load_settings(0, 0, 127, 255, 127, 100, 45, 255);
    queue_traffic(50);
    drain();

    repeat (2) begin
      load_random_settings();
      queue_traffic(90);
      drain();
    end

    load_random_settings();
    squeeze_req = 1'b1;
    queue_traffic(90);
    drain();

    calm = 1'b1;
    load_settings(ptss_pkg::CFG_RESET.ramp_step_deg,
                  ptss_pkg::CFG_RESET.idle_timeout_ticks,
                  ptss_pkg::CFG_RESET.home_pan_deg, ptss_pkg::CFG_RESET.home_tilt_deg,
                  ptss_pkg::CFG_RESET.step_level_one, ptss_pkg::CFG_RESET.step_level_two,
                  ptss_pkg::CFG_RESET.step_level_three,
                  ptss_pkg::CFG_RESET.pan_limit_deg);
    queue_traffic(90);
    drain();
    repeat (8) @(negedge clk);

    $display("Drove %0d words and checked %0d results under %0d register settings",
             words_in, words_out, settings_used + 1);
    $display("(%0d register writes, one long output stall, %0d failures)",
             reg_writes, fail_count);
    if (fail_count == 0 && pose_expect_q.size() == 0) begin
      $display("pan_tilt_command_slew_servo_core verification clean");
    end else begin
      $display("pan_tilt_command_slew_servo_core verification failed");
    end
    $finish;
  end

endmodule
